### sv/xec_pkg.sv
`default_nettype none

package xec_pkg;

   localparam int NUM_ENT  = 5;
   localparam int MAX_RUN  = 6;
   localparam int HOLD_LEN = 4;

   localparam logic [7:0] AMP = 8'h26;

   localparam logic [7:0] ENT_TEXT [0:NUM_ENT-1][0:4] = '{
      '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
      '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
      '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
      '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
      '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}
   };

   localparam logic [2:0] ENT_LEN [0:NUM_ENT-1] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};

   localparam logic [7:0] ENT_RAW [0:NUM_ENT-1] = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22};

   typedef enum logic [1:0] {
      MATCH_NONE,
      MATCH_PREFIX,
      MATCH_FULL
   } match_kind_type;

   typedef struct packed {
      match_kind_type kind;
      logic [2:0]     which;
   } match_type;

   typedef struct packed {
      logic [MAX_RUN-1:0][7:0] bytes;
      logic [2:0]              count;
      logic                    last;
   } run_type;

   typedef struct packed {
      logic    valid;
      run_type run;
   } head_type;

   function automatic match_type match_entity(
      input logic [HOLD_LEN-1:0][7:0] held,
      input logic [2:0]               held_count,
      input logic [7:0]               b
   );
      match_type  r;
      logic       ok;
      logic [2:0] k;
      r.kind  = MATCH_NONE;
      r.which = '0;
      k       = held_count - 3'd1;
      for (int e = 0; e < NUM_ENT; e++) begin
         ok = (held_count <= ENT_LEN[e]);
         for (int i = 0; i < HOLD_LEN; i++) begin
            if (3'(i) < k && held[i] != ENT_TEXT[e][i]) begin
               ok = 1'b0;
            end
         end
         if (ENT_TEXT[e][k] != b) begin
            ok = 1'b0;
         end
         if (ok && held_count == ENT_LEN[e] && r.kind != MATCH_FULL) begin
            r.kind  = MATCH_FULL;
            r.which = 3'(e);
         end else if (ok && r.kind == MATCH_NONE) begin
            r.kind = MATCH_PREFIX;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/xec_intf.sv
`default_nettype none

interface xec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface xec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       message_end;

   modport source (output valid, output out_byte, output run_last, output message_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input message_end,
                 output ready);
endinterface

`default_nettype wire

### sv/xec_front.sv
`default_nettype none

module xec_front (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata,
   xec_req_if.sink           req_if,
   input  wire logic         q_full,
   output xec_pkg::run_type  push_run,
   output logic              push
);

   logic                                 mode_ff;
   logic [2:0]                           pc_ff;
   logic [2:0]                           pc_in;
   logic [xec_pkg::HOLD_LEN-1:0][7:0]    pb_ff;
   logic                                 pb_we;
   logic                                 accept;
   logic [2:0]                           n;
   logic [xec_pkg::MAX_RUN-1:0][7:0]     slots;
   logic [xec_pkg::MAX_RUN-1:0][7:0]     bytes;
   xec_pkg::match_type                   mt;
   logic [7:0]                           b;
   logic                                 last;

   assign b             = req_if.in_byte;
   assign last          = req_if.in_last;
   assign req_if.ready  = !q_full;
   assign accept        = req_if.valid && req_if.ready;
   assign mt            = xec_pkg::match_entity(pb_ff, pc_ff, b);

   always_comb begin
      slots[0] = (pc_ff == 3'd0) ? b : xec_pkg::AMP;
      for (int i = 1; i <= xec_pkg::HOLD_LEN; i++) begin
         slots[i] = (pc_ff == 3'(i)) ? b : pb_ff[i-1];
      end
      slots[xec_pkg::MAX_RUN-1] = b;
   end

   always_comb begin
      bytes = slots;
      n     = 3'd0;
      pc_in = pc_ff;
      pb_we = 1'b0;
      if (mode_ff) begin
         bytes[0] = b;
         n        = 3'd1;
         for (int e = 0; e < xec_pkg::NUM_ENT; e++) begin
            if (b == xec_pkg::ENT_RAW[e]) begin
               bytes[0] = xec_pkg::AMP;
               for (int i = 0; i < 5; i++) begin
                  bytes[i+1] = xec_pkg::ENT_TEXT[e][i];
               end
               n = xec_pkg::ENT_LEN[e] + 3'd1;
            end
         end
      end else if (pc_ff != 3'd0 && mt.kind == xec_pkg::MATCH_FULL) begin
         bytes[0] = xec_pkg::ENT_RAW[mt.which];
         n        = 3'd1;
         pc_in    = 3'd0;
      end else if (pc_ff != 3'd0 && mt.kind == xec_pkg::MATCH_PREFIX) begin
         pb_we = 1'b1;
         n     = last ? pc_ff + 3'd1 : 3'd0;
         pc_in = last ? 3'd0 : pc_ff + 3'd1;
      end else begin
         n     = pc_ff + {2'b00, (b != xec_pkg::AMP) || last};
         pc_in = (b == xec_pkg::AMP && !last) ? 3'd1 : 3'd0;
      end
   end

   assign push           = accept && (n != 3'd0);
   assign push_run.bytes = bytes;
   assign push_run.count = n;
   assign push_run.last  = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         pc_ff   <= 3'd0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
         pc_ff   <= 3'd0;
      end else if (accept) begin
         pc_ff <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pb_we) begin
         pb_ff[2'(pc_ff - 3'd1)] <= b;
      end
   end

endmodule

`default_nettype wire

### sv/xec_queue.sv
`default_nettype none

module xec_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire xec_pkg::run_type push_run,
   input  wire logic          pop,
   output logic               full,
   output xec_pkg::head_type  head
);

   xec_pkg::run_type mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       level_ff;
   logic [1:0]       level_in;

   assign full       = (level_ff == 2'd2);
   assign head.valid = (level_ff != 2'd0);
   assign head.run   = mem_ff[rd_ptr_ff];

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 2'd1;
      end else if (pop && !push) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

`default_nettype wire

### sv/xec_back.sv
`default_nettype none

module xec_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire xec_pkg::head_type head,
   output logic               pop,
   xec_rsp_if.source          rsp_if
);

   logic [2:0] idx_ff;
   logic       at_end;
   logic       take;

   assign at_end             = (idx_ff == head.run.count - 3'd1);
   assign rsp_if.valid       = head.valid;
   assign rsp_if.out_byte    = head.run.bytes[idx_ff];
   assign rsp_if.run_last    = at_end;
   assign rsp_if.message_end = at_end && head.run.last;
   assign take               = rsp_if.valid && rsp_if.ready;
   assign pop                = take && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else if (take) begin
         idx_ff <= at_end ? 3'd0 : idx_ff + 3'd1;
      end
   end

endmodule

`default_nettype wire

### sv/xec_core_top.sv
`default_nettype none

`default_nettype wire

### sv/xml_entity_codec.sv
`default_nettype none

// Channel   Dir  Handshake      Word
// req_if    in   valid/ready    in_byte[7:0], in_last
// rsp_if    out  valid/ready    out_byte[7:0], run_last, message_end
// csr       in   csr_we         csr_wdata (mode: 0 decode, 1 encode)
//
// Throughput: one input word per cycle while the run queue is not full, when
// each yields one output byte; a word that expands or flushes to N bytes (up
// to 6) holds the serializer until all N are taken. Accepted runs are
// registered in the two-entry run queue. req_if.ready drops only while that
// queue is full. Reset clears mode, pending match, queue and byte index.

module xml_entity_codec (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic csr_wdata,
   xec_req_if.sink   req_if,
   xec_rsp_if.source rsp_if
);

   xec_pkg::run_type  push_run;
   xec_pkg::head_type head;
   logic              push;
   logic              pop;
   logic              full;

   xec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .q_full    (full),
      .push_run  (push_run),
      .push      (push)
   );

   xec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .full     (full),
      .head     (head)
   );

   xec_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.run_last |=> rsp_if.valid)
      else $error("run ended before its last word");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("run queue written while full");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_if.valid)
      else $error("output valid right after reset");

endmodule

`default_nettype wire

### sim/xml_entity_codec_checker.sv
`timescale 1ns / 1ps

module xml_entity_codec_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic csr_wdata,
   xec_req_if        req_if,
   xec_rsp_if        rsp_if,
   output int        fail_count,
   output int        results_owed
);

   typedef struct packed {
      logic [7:0] text;
      logic       run_last;
      logic       message_end;
   } coded_byte_type;

   logic           encode_mode;
   logic [2:0]     held_count;
   logic [7:0]     held_text [0:xec_pkg::HOLD_LEN-1];
   coded_byte_type word_run [$];
   coded_byte_type owed_bytes [$];
   coded_byte_type got;
   coded_byte_type want;
   int             failures = 0;

   initial begin
      fail_count   = 0;
      results_owed = 0;
      encode_mode  = 1'b0;
      held_count   = '0;
   end

   function automatic void put_byte(input logic [7:0] b);
      word_run.push_back({b, 1'b0, 1'b0});
   endfunction

   // emit the held ampersand and the bytes collected after it as plain text
   function automatic void spill_held();
      if (held_count != 0) begin
         put_byte(xec_pkg::AMP);
         for (int i = 0; i < int'(held_count) - 1; i++) begin
            put_byte(held_text[i]);
         end
         held_count = '0;
      end
   endfunction

   function automatic void predict_word(input logic [7:0] b, input logic last);
      xec_pkg::match_kind_type progress;
      logic                    escaped;
      logic                    ok;
      int                      k;
      int                      hit;
      word_run.delete();
      if (encode_mode) begin
         escaped = 1'b0;
         for (int e = 0; e < xec_pkg::NUM_ENT; e++) begin
            if (!escaped && b == xec_pkg::ENT_RAW[e]) begin
               escaped = 1'b1;
               put_byte(xec_pkg::AMP);
               for (int i = 0; i < int'(xec_pkg::ENT_LEN[e]); i++) begin
                  put_byte(xec_pkg::ENT_TEXT[e][i]);
               end
            end
         end
         if (!escaped) begin
            put_byte(b);
         end
      end else begin
         progress = xec_pkg::MATCH_NONE;
         k        = 0;
         hit      = 0;
         if (held_count != 0) begin
            k = int'(held_count) - 1;
            for (int e = 0; e < xec_pkg::NUM_ENT; e++) begin
               ok = (held_count <= xec_pkg::ENT_LEN[e]) && (xec_pkg::ENT_TEXT[e][k] == b);
               for (int i = 0; i < k; i++) begin
                  if (held_text[i] != xec_pkg::ENT_TEXT[e][i]) begin
                     ok = 1'b0;
                  end
               end
               if (ok && progress != xec_pkg::MATCH_FULL) begin
                  if (held_count == xec_pkg::ENT_LEN[e]) begin
                     progress = xec_pkg::MATCH_FULL;
                     hit      = e;
                  end else begin
                     progress = xec_pkg::MATCH_PREFIX;
                  end
               end
            end
         end
         if (progress == xec_pkg::MATCH_FULL) begin
            put_byte(xec_pkg::ENT_RAW[hit]);
            held_count = '0;
         end else if (progress == xec_pkg::MATCH_PREFIX) begin
            held_text[k] = b;
            held_count   = held_count + 3'd1;
         end else begin
            spill_held();
            if (b == xec_pkg::AMP) begin
               held_count = 3'd1;
            end else begin
               put_byte(b);
            end
         end
         if (last) begin
            spill_held();
         end
      end
      if (word_run.size() > 0) begin
         word_run[word_run.size() - 1].run_last = 1'b1;
         word_run[word_run.size() - 1].message_end = last;
      end
      foreach (word_run[i]) begin
         owed_bytes.push_back(word_run[i]);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         encode_mode = 1'b0;
         held_count  = '0;
         owed_bytes.delete();
      end else begin
         if (csr_we) begin
            encode_mode = csr_wdata;
            held_count  = '0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.out_byte, rsp_if.run_last, rsp_if.message_end};
            if (owed_bytes.size() == 0) begin
               if (failures < 10) begin
                  $display("%0t: unexpected word: out_byte %h run_last %b message_end %b",
                           $time, got.text, got.run_last, got.message_end);
               end
               failures++;
            end else begin
               want = owed_bytes.pop_front();
               if (got.text != want.text || got.run_last != want.run_last ||
                   got.message_end != want.message_end) begin
                  if (failures < 10) begin
                     $display("%0t: mismatch: out_byte %h/%h run_last %b/%b message_end %b/%b",
                              $time, want.text, got.text, want.run_last, got.run_last,
                              want.message_end, got.message_end);
                  end
                  failures++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            predict_word(req_if.in_byte, req_if.in_last);
         end
      end
      results_owed <= owed_bytes.size();
      fail_count   <= failures;
   end

endmodule

### sim/xml_entity_codec_tb.sv
`timescale 1ns / 1ps

module xml_entity_codec_tb;

   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 8;

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic csr_we    = 1'b0;
   logic csr_wdata = 1'b0;

   int send_idle_pct = 36;
   int recv_idle_pct = 52;
   int words_sent    = 0;
   int quiet_cycles  = 0;
   int fail_count;
   int results_owed;

   xec_req_if req_if ();
   xec_rsp_if rsp_if ();

   xml_entity_codec i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   xml_entity_codec_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++) begin
         send_word(s[i], last_at_end && (i == s.len() - 1));
      end
   endtask

   // hold the sender until every owed byte is out, then let the block settle
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_wdata <= m;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_decode_message();
      logic [7:0] msg [$];
      int         units;
      int         kind;
      int         e;
      int         n;
      units = $urandom_range(1, 5);
      repeat (units) begin
         kind = $urandom_range(0, 99);
         e    = $urandom_range(0, xec_pkg::NUM_ENT - 1);
         if (kind < 55) begin
            msg.push_back(xec_pkg::AMP);
            for (int i = 0; i < int'(xec_pkg::ENT_LEN[e]); i++) begin
               msg.push_back(xec_pkg::ENT_TEXT[e][i]);
            end
         end else if (kind < 72) begin
            n = $urandom_range(0, int'(xec_pkg::ENT_LEN[e]) - 1);
            msg.push_back(xec_pkg::AMP);
            for (int i = 0; i < n; i++) begin
               msg.push_back(xec_pkg::ENT_TEXT[e][i]);
            end
            if ($urandom_range(0, 3) != 0) begin
               msg.push_back(($urandom_range(0, 3) == 0) ? xec_pkg::AMP :
                             8'($urandom_range(0, 255)));
            end
         end else if (kind < 80) begin
            msg.push_back(xec_pkg::AMP);
         end else begin
            msg.push_back(8'($urandom_range(0, 255)));
         end
      end
      foreach (msg[i]) begin
         send_word(msg[i], i == msg.size() - 1);
         words_sent++;
      end
   endtask

   task automatic send_encode_word();
      logic [7:0] b;
      if ($urandom_range(0, 99) < 40) begin
         b = xec_pkg::ENT_RAW[$urandom_range(0, xec_pkg::NUM_ENT - 1)];
      end else begin
         b = 8'($urandom_range(0, 255));
      end
      send_word(b, $urandom_range(0, 7) == 0);
      words_sent++;
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.in_byte = '0;
      req_if.in_last = 1'b0;
      rsp_if.ready   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_text("&gt;", 1'b0);
      send_text("&apos;", 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hff, 1'b1);
      send_text("&apo&", 1'b1);
      send_text("&qu", 1'b0);
      drain_results();
      write_mode(1'b1);
      send_text("<>&'\"", 1'b0);
      send_word(8'hff, 1'b1);
      drain_results();
      write_mode(1'b0);

      words_sent = 0;
      while (words_sent < 75) send_decode_message();
      drain_results();
      while (words_sent < 150) send_decode_message();
      drain_results();
      write_mode(1'b1);

      send_idle_pct = 52;
      recv_idle_pct = 36;
      while (words_sent < 250) send_encode_word();
      drain_results();
      write_mode(1'b0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (words_sent < 410) send_decode_message();

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && results_owed == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
